### rtl/transport_receive_loss_tracker_core_defines.svh
// Assertion macros shared by the loss tracker checker.
`ifndef TRANSPORT_RECEIVE_LOSS_TRACKER_CORE_DEFINES_SVH
`define TRANSPORT_RECEIVE_LOSS_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TRLT_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every edge including reset.
`define TRLT_ASSERT_NEXT(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### rtl/trlt_pkg.sv
// Package of the loss tracker: constants, state encoding and bit search.
`default_nettype none
package trlt_pkg;
    localparam int SEQ_W  = 12;
    localparam int CNT_W  = SEQ_W + 1;
    localparam int COL_W  = 6;
    localparam int ROW_W  = SEQ_W - COL_W;
    localparam int ROW_BITS = 1 << COL_W;
    localparam int ROWS   = 1 << ROW_W;
    localparam int TIME_W = 64;
    localparam int IVL_W  = 32;
    localparam int WIN_W  = 21;
    localparam int IDX_W  = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 128;

    localparam logic [IDX_W-1:0] REG_ACK_IVL = 2'd0;
    localparam logic [IDX_W-1:0] REG_NAK_IVL = 2'd1;
    localparam logic [IDX_W-1:0] REG_EXP_IVL = 2'd2;
    localparam logic [IDX_W-1:0] REG_WINDOW  = 2'd3;

    localparam logic [IVL_W-1:0] ACK_IVL_RESET = 32'd10000;
    localparam logic [IVL_W-1:0] NAK_IVL_RESET = 32'd300000;
    localparam logic [IVL_W-1:0] EXP_IVL_RESET = 32'd300000;
    localparam logic [WIN_W-1:0] WINDOW_RESET  = 21'd25600;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DCHK,
        ST_TICK,
        ST_ADV_RD,
        ST_ADV_CHK,
        ST_SUM,
        ST_FIN
    } t_state;

    // lowest clear bit of a row word
    function automatic logic [COL_W-1:0] first_zero(input logic [ROW_BITS-1:0] w);
        logic [COL_W-1:0] r;
        r = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r = COL_W'(i);
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/trlt_bitmap.sv
// Received-number bitmap memory, one row of bits per word, registered read.
`default_nettype none
module trlt_bitmap (
    input  wire                                i_clk,
    input  wire                                i_we,
    input  wire  [trlt_pkg::ROW_W-1:0]         i_waddr,
    input  wire  [trlt_pkg::ROW_BITS-1:0]      i_wdata,
    input  wire  [trlt_pkg::ROW_W-1:0]         i_raddr,
    output logic [trlt_pkg::ROW_BITS-1:0]      o_rdata
);
    import trlt_pkg::*;

    logic [ROW_BITS-1:0] r_mem [ROWS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/transport_receive_loss_tracker_core.sv
// Top level of the receive-side loss tracker with ACK/NAK/expiry timers.
// Usage:
//   Input words on s_axis: tuser is the command (data or timer tick),
//   tdata holds the sequence number and the current time. Every input word
//   yields exactly one result word on m_axis with ACK/NAK decisions, loss
//   summary (first missing number, missing count), duplicate flag and the
//   next tick deadline.
//   The received bitmap sits in a 64-row by 64-bit memory. A tick runs
//   TICK, SUM, FIN; data runs DCHK, ADV_RD and ADV_CHK per row walked (at
//   most 64 rows) as the contiguous point advances, SUM, FIN. The row walk
//   sets the rate. Missing numbers are derived from the bitmap, the contiguous
//   point and the highest number seen, so no second bitmap is kept.
//   Reset runs a clearing pass over the bitmap; s_axis_tready stays
//   low until it ends. Configuration writes are taken at any time.
//   A stalled result is held in the output register; the next input word is
//   taken meanwhile and its result waits until the register frees.
`default_nettype none
module transport_receive_loss_tracker_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [trlt_pkg::IDX_W-1:0]          i_cfg_index,
    input  wire  [trlt_pkg::IVL_W-1:0]          i_cfg_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [11:0] seq, [75:12] now, [79:76] zero
    input  wire  [trlt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] cmd
    input  wire                                 s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [0] ack_send, [13:1] ack_number, [14] nak_send, [26:15] first_missing,
    // [39:27] missing_total, [60:40] window_out, [61] duplicate,
    // [125:62] next_tick, [127:126] zero
    output logic [trlt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import trlt_pkg::*;

    t_state r_state, n_state;

    logic [IVL_W-1:0]  r_ack_ivl, r_nak_ivl, r_exp_ivl;
    logic [WIN_W-1:0]  r_window;

    logic [CNT_W-1:0]  r_ne, n_ne;
    logic [CNT_W-1:0]  r_hi, n_hi;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TIME_W-1:0] r_lat, n_lat, r_lnt, n_lnt, r_lpt, n_lpt;
    logic [ROW_W-1:0]  r_clr, n_clr;

    logic [SEQ_W-1:0]  r_seq;
    logic [TIME_W-1:0] r_now;

    logic              r_ack, n_ack, r_nak, n_nak, r_dup, n_dup;
    logic [CNT_W-1:0]  r_acknum, n_acknum, r_total, n_total;
    logic [SEQ_W-1:0]  r_first, n_first;
    logic [TIME_W-1:0] r_da, r_dn, r_de;

    logic              r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic              out_free;

    logic              mem_we;
    logic [ROW_W-1:0]  mem_waddr, mem_raddr;
    logic [ROW_BITS-1:0] mem_wdata, mem_rdata;

    logic [COL_W-1:0]  q_col;
    logic [CNT_W-1:0]  q_ext;
    logic [ROW_BITS-1:0] adv_mask;
    logic [CNT_W-1:0]  next_row_base;
    logic [TIME_W-1:0] dmin, dmin2;
    logic [WIN_W-1:0]  win_out;

    trlt_bitmap u_bitmap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign q_col    = r_seq[COL_W-1:0];
    assign q_ext    = {1'b0, r_seq};
    assign adv_mask = mem_rdata | ((ROW_BITS'(1) << r_ne[COL_W-1:0]) - ROW_BITS'(1));
    assign next_row_base = {r_ne[CNT_W-1:COL_W] + (CNT_W-COL_W)'(1), {COL_W{1'b0}}};

    assign dmin    = (r_dn < r_da) ? r_dn : r_da;
    assign dmin2   = (r_de < dmin) ? r_de : dmin;
    assign win_out = (r_ack || r_nak) ? r_window : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_ivl <= ACK_IVL_RESET;
            r_nak_ivl <= NAK_IVL_RESET;
            r_exp_ivl <= EXP_IVL_RESET;
            r_window  <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ACK_IVL: r_ack_ivl <= i_cfg_data;
                REG_NAK_IVL: r_nak_ivl <= i_cfg_data;
                REG_EXP_IVL: r_exp_ivl <= i_cfg_data;
                REG_WINDOW:  r_window  <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ne     <= '0;
            r_hi     <= '0;
            r_cnt    <= '0;
            r_lat    <= '0;
            r_lnt    <= '0;
            r_lpt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ne    <= n_ne;
            r_hi    <= n_hi;
            r_cnt   <= n_cnt;
            r_lat   <= n_lat;
            r_lnt   <= n_lnt;
            r_lpt   <= n_lpt;
            if (r_state == ST_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_seq <= s_axis_tdata[SEQ_W-1:0];
            r_now <= s_axis_tdata[SEQ_W+TIME_W-1:SEQ_W];
        end
        r_ack    <= n_ack;
        r_nak    <= n_nak;
        r_dup    <= n_dup;
        r_acknum <= n_acknum;
        r_first  <= n_first;
        r_total  <= n_total;
        if (r_state == ST_SUM) begin
            r_da <= r_lat + TIME_W'(r_ack_ivl);
            r_dn <= r_lnt + TIME_W'(r_nak_ivl);
            r_de <= r_lpt + TIME_W'(r_exp_ivl);
        end
        if (r_state == ST_FIN && out_free) begin
            r_odata <= {2'b00, dmin2, r_dup, win_out, r_total, r_first, r_nak,
                        r_acknum, r_ack};
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_ne      = r_ne;
        n_hi      = r_hi;
        n_cnt     = r_cnt;
        n_lat     = r_lat;
        n_lnt     = r_lnt;
        n_lpt     = r_lpt;
        n_ack     = r_ack;
        n_nak     = r_nak;
        n_dup     = r_dup;
        n_acknum  = r_acknum;
        n_first   = r_first;
        n_total   = r_total;
        mem_we    = 1'b0;
        mem_waddr = r_seq[SEQ_W-1:COL_W];
        mem_wdata = mem_rdata | (ROW_BITS'(1) << q_col);
        mem_raddr = r_ne[SEQ_W-1:COL_W];
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + ROW_W'(1);
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                mem_raddr = s_axis_tdata[SEQ_W-1:COL_W];
                if (s_axis_tvalid) begin
                    n_ack    = 1'b0;
                    n_nak    = 1'b0;
                    n_dup    = 1'b0;
                    n_acknum = '0;
                    n_first  = '0;
                    n_total  = '0;
                    n_state  = (s_axis_tuser == CMD_TICK) ? ST_TICK : ST_DCHK;
                end
            end
            ST_DCHK: begin
                if (mem_rdata[q_col]) begin
                    n_dup   = 1'b1;
                    n_state = ST_SUM;
                end else begin
                    mem_we = 1'b1;
                    if (q_ext > r_ne) begin
                        n_nak   = 1'b1;
                        n_first = r_ne[SEQ_W-1:0];
                        n_total = (q_ext > r_hi) ? r_cnt + (q_ext - r_hi) : r_cnt;
                        n_lnt   = r_now;
                    end
                    if (q_ext >= r_hi) begin
                        n_cnt = r_cnt + (q_ext - r_hi);
                        n_hi  = q_ext + CNT_W'(1);
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                    n_lpt   = r_now;
                    n_state = (q_ext == r_ne) ? ST_ADV_RD : ST_SUM;
                end
            end
            ST_TICK: begin
                if ((r_now - r_lat) >= TIME_W'(r_ack_ivl) && r_ne != '0) begin
                    n_ack    = 1'b1;
                    n_acknum = r_ne;
                    n_lat    = r_now;
                end
                if (r_cnt != '0 && (r_now - r_lnt) >= TIME_W'(r_nak_ivl)) begin
                    n_nak   = 1'b1;
                    n_first = r_ne[SEQ_W-1:0];
                    n_total = r_cnt;
                    n_lnt   = r_now;
                end
                if ((r_now - r_lpt) >= TIME_W'(r_exp_ivl)) begin
                    n_lpt = r_now;
                end
                n_state = ST_SUM;
            end
            ST_ADV_RD: begin
                n_state = ST_ADV_CHK;
            end
            ST_ADV_CHK: begin
                if (&adv_mask) begin
                    n_ne    = next_row_base;
                    n_state = next_row_base[CNT_W-1] ? ST_SUM : ST_ADV_RD;
                end else begin
                    n_ne    = {r_ne[CNT_W-1:COL_W], first_zero(adv_mask)};
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### rtl/trlt_checker.sv
// Port-level checker of the loss tracker and its bind to the top level.
`default_nettype none
`include "transport_receive_loss_tracker_core_defines.svh"
module trlt_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tready,
    input  wire                                 m_axis_tvalid,
    input  wire                                 m_axis_tready,
    input  wire  [trlt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import trlt_pkg::*;

    `TRLT_ASSERT_NEXT(a_rst_no_out, i_clk, !i_rst_n, !m_axis_tvalid && !s_axis_tready)
    `TRLT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n && m_axis_tvalid && !m_axis_tready, !i_rst_n || (m_axis_tvalid && $stable(m_axis_tdata)))
    `TRLT_ASSERT_IMPLY(a_acknum_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[13:1] == '0)
    `TRLT_ASSERT_IMPLY(a_win_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0] && !m_axis_tdata[14], m_axis_tdata[60:40] == '0)
endmodule

bind transport_receive_loss_tracker_core trlt_checker u_trlt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

### verif/transport_receive_loss_tracker_core_tb.sv
// Testbench of the receive loss tracker: directed table and random traffic vs. a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module transport_receive_loss_tracker_core_tb;
    import trlt_pkg::*;

    typedef struct packed {
        logic [1:0]  pad;
        logic [63:0] next_tick;
        logic        dup;
        logic [20:0] window;
        logic [12:0] total;
        logic [11:0] first;
        logic        nak;
        logic [12:0] ack_num;
        logic        ack;
    } t_report;

    typedef struct {
        logic        cmd;
        logic [11:0] seq;
        logic [63:0] now;
        bit          known;
        t_report     exp;
    } t_row;

    localparam int SPACE = 4096;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [127:0] m_axis_tdata;

    // tracker copy
    bit          got_bits [SPACE];
    bit          lost_bits[SPACE];
    logic [12:0] next_exp;
    logic [12:0] lost_cnt;
    logic [63:0] ack_stamp, nak_stamp, progress_stamp;
    logic [31:0] ack_ivl, nak_ivl, exp_ivl;
    logic [20:0] window;

    t_report     pending_reports[$];
    int          errors;
    int          words_in, words_out, acks_seen, naks_seen, dups_seen;
    int          idle_cycles;
    bit          quiet;

    transport_receive_loss_tracker_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [11:0] lowest_lost();
        if (lost_cnt == 0) return '0;
        for (int s = next_exp; s < SPACE; s++) begin
            if (lost_bits[s]) return 12'(s);
        end
        return '0;
    endfunction

    function automatic logic [63:0] earliest_deadline();
        logic [63:0] t, n, e;
        t = ack_stamp + 64'(ack_ivl);
        n = nak_stamp + 64'(nak_ivl);
        e = progress_stamp + 64'(exp_ivl);
        if (n < t) t = n;
        if (e < t) t = e;
        return t;
    endfunction

    function automatic t_report track_word(logic cmd, logic [11:0] seq, logic [63:0] now);
        t_report r;
        int q;
        r = '0;
        q = seq;
        if (cmd == CMD_DATA) begin
            if (got_bits[q]) begin
                r.dup = 1'b1;
            end else begin
                got_bits[q] = 1'b1;
                if (q > next_exp) begin
                    for (int s = next_exp; s < q; s++) begin
                        if (!got_bits[s] && !lost_bits[s]) begin
                            lost_bits[s] = 1'b1;
                            lost_cnt++;
                        end
                    end
                    r.nak = 1'b1;
                    r.first = lowest_lost();
                    r.total = lost_cnt;
                    nak_stamp = now;
                end
                if (lost_bits[q]) begin
                    lost_bits[q] = 1'b0;
                    lost_cnt--;
                end
                while (next_exp < SPACE && got_bits[next_exp]) next_exp++;
                progress_stamp = now;
            end
        end else begin
            if (now - ack_stamp >= 64'(ack_ivl) && next_exp > 0) begin
                r.ack = 1'b1;
                r.ack_num = next_exp;
                ack_stamp = now;
            end
            if (lost_cnt > 0 && now - nak_stamp >= 64'(nak_ivl)) begin
                r.nak = 1'b1;
                r.first = lowest_lost();
                r.total = lost_cnt;
                nak_stamp = now;
            end
            if (now - progress_stamp >= 64'(exp_ivl)) progress_stamp = now;
        end
        if (r.ack || r.nak) r.window = window;
        r.next_tick = earliest_deadline();
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            REG_ACK_IVL: ack_ivl = value;
            REG_NAK_IVL: nak_ivl = value;
            REG_EXP_IVL: exp_ivl = value;
            REG_WINDOW:  window = value[20:0];
            default: ;
        endcase
    endtask

    // offer one word, hold until taken, then log what it should produce
    task automatic send_word(logic cmd, logic [11:0] seq, logic [63:0] now,
                             bit known, t_report fixed);
        t_report r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {4'b0, now, seq};
        do @(posedge i_clk); while (!s_axis_tready);
        r = track_word(cmd, seq, now);
        pending_reports.push_back(known ? fixed : r);
        words_in++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // check results
    always @(posedge i_clk) begin
        t_report got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_report'(m_axis_tdata);
            words_out++;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %p", got);
            end else begin
                want = pending_reports.pop_front();
                acks_seen += want.ack;
                naks_seen += want.nak;
                dups_seen += want.dup;
                if (got.ack !== want.ack || got.ack_num !== want.ack_num ||
                    got.nak !== want.nak || got.first !== want.first ||
                    got.total !== want.total || got.window !== want.window ||
                    got.dup !== want.dup || got.next_tick !== want.next_tick ||
                    got.pad !== want.pad) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at word %0d\n  expected %p\n  actual   %p",
                                 words_out, want, got);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off
    initial begin
        bit held;
        held = 0;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && words_in >= 200) begin
                held = 1;
                m_axis_tready <= 1'b0;
                repeat (500) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_row        rows[$];
        t_report     r0;
        logic [63:0] now;
        logic [11:0] seq;
        logic        cmd;
        int          pick;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_DATA;
        errors = 0;
        words_in = 0; words_out = 0;
        acks_seen = 0; naks_seen = 0; dups_seen = 0;
        quiet = 0;
        next_exp = '0; lost_cnt = '0;
        ack_stamp = '0; nak_stamp = '0; progress_stamp = '0;
        ack_ivl = ACK_IVL_RESET; nak_ivl = NAK_IVL_RESET;
        exp_ivl = EXP_IVL_RESET; window = WINDOW_RESET;
        r0 = '0;
        r0.next_tick = 64'd10000;

        rows.push_back('{CMD_TICK, 12'd0, 64'd0, 1, r0});
        rows.push_back('{CMD_DATA, 12'd0, 64'd5, 1, r0});
        r0.dup = 1'b1;
        rows.push_back('{CMD_DATA, 12'd0, 64'd6, 1, r0});
        r0.dup = 1'b0;
        r0.nak = 1'b1; r0.first = 12'd1; r0.total = 13'd2; r0.window = 21'd25600;
        rows.push_back('{CMD_DATA, 12'd3, 64'd7, 1, r0});
        rows.push_back('{CMD_DATA, 12'd3, 64'd8, 0, r0});
        rows.push_back('{CMD_DATA, 12'd2, 64'd9, 0, r0});
        rows.push_back('{CMD_DATA, 12'd1, 64'd10, 0, r0});
        rows.push_back('{CMD_TICK, 12'hFFF, 64'd10007, 0, r0});
        rows.push_back('{CMD_DATA, 12'd10, 64'd10010, 0, r0});
        rows.push_back('{CMD_DATA, 12'd6, 64'd10011, 0, r0});
        rows.push_back('{CMD_TICK, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0, r0});
        rows.push_back('{CMD_TICK, 12'd0, 64'd0, 0, r0});
        rows.push_back('{CMD_DATA, 12'hFFF, 64'h8000_0000_0000_0000, 0, r0});
        rows.push_back('{CMD_DATA, 12'hFFF, 64'h8000_0000_0000_0001, 0, r0});
        rows.push_back('{CMD_TICK, 12'hAAA, 64'h8000_0000_0006_1A80, 0, r0});
        rows.push_back('{CMD_DATA, 12'd4, 64'h8000_0000_0006_1A81, 0, r0});
        rows.push_back('{CMD_DATA, 12'd5, 64'h8000_0000_0006_1A82, 0, r0});
        rows.push_back('{CMD_DATA, 12'h555, 64'h7FFF_FFFF_FFFF_FFFF, 0, r0});
        rows.push_back('{CMD_TICK, 12'd0, 64'hFFFF_FFFF_0000_0000, 0, r0});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_word(rows[i].cmd, rows[i].seq, rows[i].now,
                                    rows[i].known, rows[i].exp);
        drain();

        now = 64'h8000_0000_0010_0000;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_ACK_IVL, 32'd0);
                    write_reg(REG_NAK_IVL, 32'd0);
                    write_reg(REG_EXP_IVL, 32'd0);
                    write_reg(REG_WINDOW, 32'd0);
                end
                1: begin
                    write_reg(REG_ACK_IVL, 32'd50);
                    write_reg(REG_NAK_IVL, 32'd200);
                    write_reg(REG_EXP_IVL, 32'd500);
                    write_reg(REG_WINDOW, 32'd1048576);
                end
                2: begin
                    write_reg(REG_ACK_IVL, 32'hFFFF_FFFF);
                    write_reg(REG_NAK_IVL, 32'hFFFF_FFFF);
                    write_reg(REG_EXP_IVL, 32'hFFFF_FFFF);
                    write_reg(REG_WINDOW, 32'hFFFF_FFFF);
                end
                default: begin
                    write_reg(REG_ACK_IVL, $urandom_range(0, 150));
                    write_reg(REG_NAK_IVL, $urandom_range(0, 400));
                    write_reg(REG_EXP_IVL, $urandom_range(0, 600));
                    write_reg(REG_WINDOW, $urandom);
                end
            endcase
            i_cfg_we <= 1'b0;
            for (int n = 0; n < 110; n++) begin
                quiet = (phase == 3 && n >= 60);
                if ($urandom_range(0, 19) == 0)
                    now = {$urandom, $urandom};
                else
                    now = now + 64'($urandom_range(0, 300));
                pick = $urandom_range(0, 99);
                cmd = (pick < 30) ? CMD_TICK : CMD_DATA;
                if (pick < 30)
                    seq = 12'($urandom);
                else if (pick < 80)
                    seq = (next_exp + $urandom_range(0, 24) > SPACE - 1) ? 12'hFFF :
                          12'(next_exp + $urandom_range(0, 24));
                else if (pick < 90 && next_exp > 0)
                    seq = 12'($urandom_range(0, next_exp - 1));
                else
                    seq = 12'($urandom);
                send_word(cmd, seq, now, 0, '0);
            end
            drain();
        end

        $display("covered %0d words: %0d ACKs, %0d NAKs, %0d duplicates, contiguous point %0d",
                 words_in, acks_seen, naks_seen, dups_seen, next_exp);
        $display("four register settings incl. zero and all-ones intervals, long output stall");
        if (errors == 0 && pending_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/trlt_pkg.sv
rtl/trlt_bitmap.sv
rtl/transport_receive_loss_tracker_core.sv
rtl/trlt_checker.sv
verif/transport_receive_loss_tracker_core_tb.sv
